// ----- sv/hcbd_pkg.sv -----
// Package for the chunked body deframer: phase codes, result kinds,
// framing characters and the hex digit decoder. No dependencies.
`default_nettype none

package hcbd_pkg;

  localparam int SIZE_BITS_DEF = 32;

  typedef enum logic [7:0] {
    PH_SIZE     = 8'b0000_0001,
    PH_SIZE_LF  = 8'b0000_0010,
    PH_DATA     = 8'b0000_0100,
    PH_DATA_CR  = 8'b0000_1000,
    PH_DATA_LF  = 8'b0001_0000,
    PH_TRAIL_CR = 8'b0010_0000,
    PH_TRAIL_LF = 8'b0100_0000,
    PH_DONE     = 8'b1000_0000
  } phase_t;

  typedef logic [1:0] kind_t;

  localparam kind_t KIND_FRAME   = 2'd0;
  localparam kind_t KIND_PAYLOAD = 2'd1;
  localparam kind_t KIND_DONE    = 2'd2;
  localparam kind_t KIND_IGNORED = 2'd3;

  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_SEMI  = 8'h3B;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_digit_t;

  function automatic hex_digit_t hex_decode(input logic [7:0] b);
    hex_digit_t r;
    r.valid = 1'b1;
    r.value = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r.value = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r.value = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r.value = 4'(b - 8'h37);
    end else begin
      r.valid = 1'b0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- sv/hcbd_if.sv -----
// Valid/ready channel interfaces for the chunked body deframer:
// body byte input and result output. Depends on hcbd_pkg.
`default_nettype none

interface hcbd_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] in_byte;

  modport source(output valid, output operation, output in_byte, input ready);
  modport sink(input valid, input operation, input in_byte, output ready);
endinterface

interface hcbd_out_if;
  logic            valid;
  logic            ready;
  hcbd_pkg::kind_t kind;
  logic [7:0]      payload_byte;

  modport source(output valid, output kind, output payload_byte, input ready);
  modport sink(input valid, input kind, input payload_byte, output ready);
endinterface

`default_nettype wire

// ----- sv/http_chunked_body_deframer_core.sv -----
// Top level of the HTTP chunked body deframer.
// Depends on hcbd_pkg and the channel interfaces in hcbd_if.sv.
//
// Usage: body bytes enter on in_ch, one beat per byte, with operation
// selecting a body byte or a restart for a new body. Every input beat
// yields exactly one output beat on out_ch, giving its kind (framing,
// payload, body complete, ignored after done) and the payload byte.
// The output is valid in the cycle after the input beat is taken. One
// beat is accepted per cycle while the receiver keeps up; the phase,
// chunk size and bytes-left registers are updated in the same cycle the
// beat is taken, and the result lands in a single output register.
// When the receiver stalls, the output register holds its beat and
// in_ch.ready stays high only if that beat is taken in the same cycle.
// Synchronous active-low reset returns the parser to the size phase with
// zero size and empties the output register; no warm-up is needed.
`default_nettype none

module http_chunked_body_deframer_core #(
  parameter int SIZE_BITS = hcbd_pkg::SIZE_BITS_DEF
) (
  input  wire           clk,
  input  wire           rst_n,
  hcbd_in_if.sink       in_ch,
  hcbd_out_if.source    out_ch
);

  hcbd_pkg::phase_t     phase_r, phase_nxt;
  logic [SIZE_BITS-1:0] bytes_left_r, bytes_left_nxt;
  logic [SIZE_BITS-1:0] size_accum_r, size_accum_nxt;
  logic                 digits_ended_r, digits_ended_nxt;
  logic                 out_valid_r;
  hcbd_pkg::kind_t      kind_r, kind_nxt;
  logic [7:0]           payload_r, payload_nxt;
  logic                 in_fire;
  hcbd_pkg::hex_digit_t digit;
  logic [7:0]           b;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign b           = in_ch.in_byte;
  assign digit       = hcbd_pkg::hex_decode(b);

  always_comb begin
    phase_nxt        = phase_r;
    bytes_left_nxt   = bytes_left_r;
    size_accum_nxt   = size_accum_r;
    digits_ended_nxt = digits_ended_r;
    kind_nxt         = hcbd_pkg::KIND_FRAME;
    payload_nxt      = 8'd0;
    if (in_ch.operation == hcbd_pkg::OP_RESTART) begin
      phase_nxt        = hcbd_pkg::PH_SIZE;
      bytes_left_nxt   = '0;
      size_accum_nxt   = '0;
      digits_ended_nxt = 1'b0;
    end else begin
      case (phase_r)
        hcbd_pkg::PH_SIZE: begin
          if (b == hcbd_pkg::CHAR_CR) begin
            phase_nxt = hcbd_pkg::PH_SIZE_LF;
          end else if (b == hcbd_pkg::CHAR_SEMI) begin
            digits_ended_nxt = 1'b1;
          end else if (b != hcbd_pkg::CHAR_SPACE && !digits_ended_r) begin
            if (!digit.valid) begin
              digits_ended_nxt = 1'b1;
            end else if (|size_accum_r[SIZE_BITS-1 -: 4]) begin
              size_accum_nxt = '1;
            end else begin
              size_accum_nxt = {size_accum_r[SIZE_BITS-5:0], digit.value};
            end
          end
        end
        hcbd_pkg::PH_SIZE_LF: begin
          if (b == hcbd_pkg::CHAR_LF) begin
            bytes_left_nxt   = size_accum_r;
            size_accum_nxt   = '0;
            digits_ended_nxt = 1'b0;
            phase_nxt        = (size_accum_r == '0) ? hcbd_pkg::PH_TRAIL_CR
                                                    : hcbd_pkg::PH_DATA;
          end
        end
        hcbd_pkg::PH_DATA: begin
          kind_nxt    = hcbd_pkg::KIND_PAYLOAD;
          payload_nxt = b;
          if (bytes_left_r != '0) begin
            bytes_left_nxt = bytes_left_r - 1'b1;
          end
          if (bytes_left_r <= SIZE_BITS'(1)) begin
            phase_nxt = hcbd_pkg::PH_DATA_CR;
          end
        end
        hcbd_pkg::PH_DATA_CR: begin
          if (b == hcbd_pkg::CHAR_CR) begin
            phase_nxt = hcbd_pkg::PH_DATA_LF;
          end
        end
        hcbd_pkg::PH_DATA_LF: begin
          if (b == hcbd_pkg::CHAR_LF) begin
            phase_nxt = hcbd_pkg::PH_SIZE;
          end
        end
        hcbd_pkg::PH_TRAIL_CR: begin
          if (b == hcbd_pkg::CHAR_CR) begin
            phase_nxt = hcbd_pkg::PH_TRAIL_LF;
          end
        end
        hcbd_pkg::PH_TRAIL_LF: begin
          if (b == hcbd_pkg::CHAR_LF) begin
            phase_nxt = hcbd_pkg::PH_DONE;
            kind_nxt  = hcbd_pkg::KIND_DONE;
          end
        end
        default: begin
          kind_nxt = hcbd_pkg::KIND_IGNORED;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= hcbd_pkg::PH_SIZE;
      bytes_left_r   <= '0;
      size_accum_r   <= '0;
      digits_ended_r <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_r        <= phase_nxt;
        bytes_left_r   <= bytes_left_nxt;
        size_accum_r   <= size_accum_nxt;
        digits_ended_r <= digits_ended_nxt;
        out_valid_r    <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r    <= kind_nxt;
      payload_r <= payload_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.kind         = kind_r;
  assign out_ch.payload_byte = payload_r;

  a_data_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == hcbd_pkg::PH_DATA |-> bytes_left_r != '0)
    else $error("data phase entered with no bytes left");

  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_ch.operation == hcbd_pkg::OP_RESTART |=>
      phase_r == hcbd_pkg::PH_SIZE && size_accum_r == '0 && !digits_ended_r
      && out_ch.kind == hcbd_pkg::KIND_FRAME)
    else $error("restart did not clear the parser");

  a_done_ignores: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_ch.operation == hcbd_pkg::OP_BYTE && phase_r == hcbd_pkg::PH_DONE
      |=> out_ch.kind == hcbd_pkg::KIND_IGNORED && phase_r == hcbd_pkg::PH_DONE)
    else $error("byte after completion was not ignored");

  a_payload_passes: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_ch.operation == hcbd_pkg::OP_BYTE && phase_r == hcbd_pkg::PH_DATA
      |=> out_ch.kind == hcbd_pkg::KIND_PAYLOAD
      && out_ch.payload_byte == $past(in_ch.in_byte))
    else $error("data byte not passed through as payload");

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for http_chunked_body_deframer_core: directed and random
// chunked bodies with a built-in deframing predictor, checked beat by beat.
// Depends on hcbd_pkg, the channel interfaces in hcbd_if.sv and the core RTL.
`default_nettype none

module tb;

  localparam int SZ          = hcbd_pkg::SIZE_BITS_DEF;
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_LIMIT  = 3000;
  localparam int TOTAL_BEATS = 1350;
  localparam logic [SZ-1:0] SIZE_MAX = '1;

  typedef struct packed {
    hcbd_pkg::kind_t kind;
    logic [7:0]      payload;
  } deframe_result_t;

  typedef enum int {RX_ALWAYS, RX_COIN, RX_ONE_IN_FOUR, RX_MOSTLY} rx_pattern_t;

  logic clk = 1'b0;
  logic rst_n;

  hcbd_in_if  in_ch();
  hcbd_out_if out_ch();

  http_chunked_body_deframer_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted parser state.
  hcbd_pkg::phase_t pr_phase = hcbd_pkg::PH_SIZE;
  logic [SZ-1:0]    pr_left = '0;
  logic [SZ-1:0]    pr_accum = '0;
  logic             pr_ended = 1'b0;

  deframe_result_t expected_results[$];

  int sent_items = 0;
  int restarts = 0;
  int results_seen = 0;
  int mismatches = 0;
  int idle_cycles = 0;
  int kind_count[4] = '{0, 0, 0, 0};

  int burst_left = 0;
  bit gaps_enabled = 1'b1;
  int noise_pct = 0;
  int char_budget = -1;
  bit hold_request = 1'b0;

  function automatic int hex_nibble(input logic [7:0] b);
    if (b >= "0" && b <= "9") return int'(b - "0");
    if (b >= "a" && b <= "f") return int'(b - "a") + 10;
    if (b >= "A" && b <= "F") return int'(b - "A") + 10;
    return -1;
  endfunction

  function automatic deframe_result_t deframe_step(input logic op, input logic [7:0] b);
    deframe_result_t r;
    int d;
    r.kind = hcbd_pkg::KIND_FRAME;
    r.payload = 8'h00;
    if (op == hcbd_pkg::OP_RESTART) begin
      pr_phase = hcbd_pkg::PH_SIZE;
      pr_left = '0;
      pr_accum = '0;
      pr_ended = 1'b0;
    end else begin
      case (pr_phase)
        hcbd_pkg::PH_SIZE: begin
          if (b == hcbd_pkg::CHAR_CR) begin
            pr_phase = hcbd_pkg::PH_SIZE_LF;
          end else if (b == hcbd_pkg::CHAR_SEMI) begin
            pr_ended = 1'b1;
          end else if (b != hcbd_pkg::CHAR_SPACE && !pr_ended) begin
            d = hex_nibble(b);
            if (d < 0) begin
              pr_ended = 1'b1;
            end else if (pr_accum > (SIZE_MAX >> 4)) begin
              pr_accum = SIZE_MAX;
            end else begin
              pr_accum = (pr_accum << 4) | SZ'(d);
            end
          end
        end
        hcbd_pkg::PH_SIZE_LF: begin
          if (b == hcbd_pkg::CHAR_LF) begin
            pr_left = pr_accum;
            pr_accum = '0;
            pr_ended = 1'b0;
            pr_phase = (pr_left == 0) ? hcbd_pkg::PH_TRAIL_CR : hcbd_pkg::PH_DATA;
          end
        end
        hcbd_pkg::PH_DATA: begin
          r.kind = hcbd_pkg::KIND_PAYLOAD;
          r.payload = b;
          if (pr_left != 0) pr_left = pr_left - 1'b1;
          if (pr_left == 0) pr_phase = hcbd_pkg::PH_DATA_CR;
        end
        hcbd_pkg::PH_DATA_CR: begin
          if (b == hcbd_pkg::CHAR_CR) pr_phase = hcbd_pkg::PH_DATA_LF;
        end
        hcbd_pkg::PH_DATA_LF: begin
          if (b == hcbd_pkg::CHAR_LF) pr_phase = hcbd_pkg::PH_SIZE;
        end
        hcbd_pkg::PH_TRAIL_CR: begin
          if (b == hcbd_pkg::CHAR_CR) pr_phase = hcbd_pkg::PH_TRAIL_LF;
        end
        hcbd_pkg::PH_TRAIL_LF: begin
          if (b == hcbd_pkg::CHAR_LF) begin
            pr_phase = hcbd_pkg::PH_DONE;
            r.kind = hcbd_pkg::KIND_DONE;
          end
        end
        default: begin
          r.kind = hcbd_pkg::KIND_IGNORED;
        end
      endcase
    end
    return r;
  endfunction

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 7))
      0: return hcbd_pkg::CHAR_CR;
      1: return hcbd_pkg::CHAR_LF;
      2: return hcbd_pkg::CHAR_SEMI;
      3: return hcbd_pkg::CHAR_SPACE;
      4: return 8'("0" + $urandom_range(0, 9));
      5: return 8'((($urandom_range(0, 1) != 0) ? "A" : "a") + $urandom_range(0, 5));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Called and returns at a rising edge. May open a sender gap at the start of each burst.
  task automatic send_beat(input logic op, input logic [7:0] b);
    logic hit;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = gaps_enabled ? $urandom_range(0, 6) : 0;
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.in_byte <= b;
    do begin
      @(negedge clk);
      hit = in_ch.ready;
      @(posedge clk);
    end while (hit !== 1'b1);
    expected_results.push_back(deframe_step(op, b));
    sent_items++;
    if (op == hcbd_pkg::OP_RESTART) restarts++;
  endtask

  task automatic send_char(input logic [7:0] b);
    if (char_budget == 0) return;
    if (char_budget > 0) char_budget--;
    if (noise_pct != 0 && $urandom_range(0, 99) < noise_pct)
      send_beat(($urandom_range(0, 24) == 0) ? hcbd_pkg::OP_RESTART : hcbd_pkg::OP_BYTE,
                noise_byte());
    send_beat(hcbd_pkg::OP_BYTE, b);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic send_size_line(input int unsigned sz);
    logic [31:0] v;
    logic [3:0] nib;
    logic [7:0] c;
    int nd;
    v = sz;
    nd = 1;
    while (nd < 8 && (v >> (4 * nd)) != 0) nd++;
    if ($urandom_range(0, 4) == 0) nd = nd + $urandom_range(1, 2);
    if (nd > 8) nd = 8;
    for (int i = nd - 1; i >= 0; i--) begin
      if ($urandom_range(0, 9) == 0) send_char(hcbd_pkg::CHAR_SPACE);
      nib = v[i*4 +: 4];
      if (nib < 10) c = 8'("0" + nib);
      else c = 8'((($urandom_range(0, 1) != 0) ? "A" : "a") + nib - 10);
      send_char(c);
    end
    if ($urandom_range(0, 3) == 0) begin
      send_char(hcbd_pkg::CHAR_SEMI);
      repeat ($urandom_range(0, 8)) begin
        c = 8'($urandom_range(0, 255));
        if (c == hcbd_pkg::CHAR_CR) c = "x";
        send_char(c);
      end
    end
    send_char(hcbd_pkg::CHAR_CR);
    send_char(hcbd_pkg::CHAR_LF);
  endtask

  task automatic wait_drained();
    if (expected_results.size() != 0) begin
      in_ch.valid <= 1'b0;
      burst_left = 0;
      while (expected_results.size() != 0) @(posedge clk);
    end
  endtask

  // Extension after a semicolon, stray bytes while CR or LF is awaited, one payload beat.
  task automatic test_size_line_quirks();
    send_text("1;f");
    send_char(hcbd_pkg::CHAR_CR);
    send_char("Z");
    send_char(hcbd_pkg::CHAR_CR);
    send_char(hcbd_pkg::CHAR_LF);
    send_char(8'hFF);
    send_char("q");
    send_char(hcbd_pkg::CHAR_CR);
    send_char(hcbd_pkg::CHAR_LF);
  endtask

  // A "0x" prefix ends the digits at zero, so the body closes right away.
  task automatic test_zero_size_completion();
    send_text("0x5");
    send_char(hcbd_pkg::CHAR_CR);
    send_char(hcbd_pkg::CHAR_LF);
    send_char("a");
    send_char(hcbd_pkg::CHAR_CR);
    send_char(hcbd_pkg::CHAR_LF);
    send_char(8'h00);
    send_beat(hcbd_pkg::OP_RESTART, 8'hFF);
  endtask

  // Nine hex digits with a space among them saturate the size register.
  task automatic test_size_saturation();
    send_text("FF FFFFFFF");
    send_char(hcbd_pkg::CHAR_CR);
    send_char(hcbd_pkg::CHAR_LF);
    send_char(8'h80);
    send_beat(hcbd_pkg::OP_RESTART, 8'h5A);
  endtask

  // The receiver holds off for a long stretch while a whole body is offered.
  task automatic test_output_stall();
    gaps_enabled = 1'b0;
    hold_request = 1'b1;
    send_beat(hcbd_pkg::OP_RESTART, 8'h00);
    send_size_line(24);
    repeat (24) send_char(8'($urandom_range(0, 255)));
    send_char(hcbd_pkg::CHAR_CR);
    send_char(hcbd_pkg::CHAR_LF);
    send_size_line(0);
    send_char(hcbd_pkg::CHAR_CR);
    send_char(hcbd_pkg::CHAR_LF);
    wait_drained();
    gaps_enabled = 1'b1;
  endtask

  task automatic test_random_bodies(input int target);
    int style;
    int sz;
    while (sent_items < target) begin
      style = $urandom_range(0, 99);
      gaps_enabled = ($urandom_range(0, 3) != 0);
      noise_pct = (style >= 75 && style < 88) ? $urandom_range(1, 8) : 0;
      char_budget = (style >= 95) ? $urandom_range(1, 40) : -1;
      send_beat(hcbd_pkg::OP_RESTART, 8'($urandom_range(0, 255)));
      if (style >= 88 && style < 95) begin
        repeat ($urandom_range(1, 40)) send_char(noise_byte());
      end else begin
        repeat ($urandom_range(0, 4)) begin
          sz = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 200) : $urandom_range(1, 16);
          send_size_line(sz);
          repeat (sz) send_char(8'($urandom_range(0, 255)));
          send_char(hcbd_pkg::CHAR_CR);
          send_char(hcbd_pkg::CHAR_LF);
        end
        send_size_line(0);
        send_char(hcbd_pkg::CHAR_CR);
        send_char(hcbd_pkg::CHAR_LF);
        repeat ($urandom_range(0, 3)) send_char(8'($urandom_range(0, 255)));
      end
      noise_pct = 0;
      char_budget = -1;
      if ($urandom_range(0, 15) == 0) wait_drained();
    end
  endtask

  initial begin : receiver
    rx_pattern_t pattern;
    int pattern_left;
    int tick;
    int hold_cnt;
    out_ch.ready = 1'b0;
    pattern = RX_ALWAYS;
    pattern_left = 0;
    tick = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_ch.ready <= 1'b0;
        for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++) @(posedge clk);
        hold_request = 1'b0;
      end
      if (pattern_left == 0) begin
        pattern = rx_pattern_t'($urandom_range(0, 3));
        pattern_left = $urandom_range(40, 400);
      end
      pattern_left--;
      tick++;
      case (pattern)
        RX_ALWAYS:      out_ch.ready <= 1'b1;
        RX_COIN:        out_ch.ready <= 1'($urandom_range(0, 1));
        RX_ONE_IN_FOUR: out_ch.ready <= (tick % 4 == 0);
        default:        out_ch.ready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  // Handshakes are sampled mid-cycle, where every signal has settled.
  always @(negedge clk) begin : result_check
    deframe_result_t want;
    bit in_fire;
    bit out_fire;
    if (rst_n === 1'b1) begin
      in_fire = (in_ch.valid === 1'b1 && in_ch.ready === 1'b1);
      out_fire = (out_ch.valid === 1'b1 && out_ch.ready === 1'b1);
      if (out_fire) begin
        if (expected_results.size() == 0) begin
          if (mismatches < 10)
            $display("ERROR result %0d: unexpected beat kind %0d payload %02h",
                     results_seen, out_ch.kind, out_ch.payload_byte);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          kind_count[want.kind]++;
          if (out_ch.kind !== want.kind || out_ch.payload_byte !== want.payload) begin
            if (mismatches < 10)
              $display("ERROR result %0d: kind %0d payload %02h, expected kind %0d payload %02h",
                       results_seen, out_ch.kind, out_ch.payload_byte, want.kind,
                       want.payload);
            mismatches++;
          end
        end
        results_seen++;
      end
      if (in_fire || out_fire) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no beat moved for %0d cycles", IDLE_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.operation = hcbd_pkg::OP_BYTE;
    in_ch.in_byte = 8'h00;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_size_line_quirks();
    test_zero_size_completion();
    test_size_saturation();
    test_output_stall();
    test_random_bodies(TOTAL_BEATS);
    wait_drained();
    repeat (8) @(posedge clk);
    $display("Run covered %0d input beats with %0d restarts and %0d results checked.",
             sent_items, restarts, results_seen);
    $display("Results by kind: %0d framing, %0d payload, %0d body complete, %0d ignored.",
             kind_count[hcbd_pkg::KIND_FRAME], kind_count[hcbd_pkg::KIND_PAYLOAD],
             kind_count[hcbd_pkg::KIND_DONE], kind_count[hcbd_pkg::KIND_IGNORED]);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
